/* sv/pitb_pkg.sv */
// pitb_pkg: widths, types and the pipeline control struct for the
// barycentric point-in-triangle pipeline
// no dependencies
package pitb_pkg;

   // coordinate width of every input field
   localparam int COORD_BITS = 16;

   // edge and offset vectors, one bit of growth
   localparam int DIFF_W = COORD_BITS + 1;
   // one element product
   localparam int PROD_W = 2 * DIFF_W;
   // sum of three element products, with room to spare
   localparam int DOT_W  = PROD_W + 2;
   // split of a dot product for the wide multiply
   localparam int LO_W   = DOT_W / 2;
   localparam int HI_W   = DOT_W - LO_W;
   // widths of the four partial products
   localparam int LL_W   = 2 * (LO_W + 1);
   localparam int HL_W   = HI_W + LO_W + 1;
   localparam int HH_W   = 2 * HI_W;
   // full product, difference of two products and sum of two differences
   localparam int WIDE_W = 2 * DOT_W + 2;

   // register stages from input to result
   localparam int STAGES = 7;
   // stage indexes
   localparam int ST_DIFF  = 0;
   localparam int ST_ELEM  = 1;
   localparam int ST_DOT   = 2;
   localparam int ST_PART  = 3;
   localparam int ST_PROD  = 4;
   localparam int ST_NUM   = 5;
   localparam int ST_RES   = 6;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [DOT_W-1:0]      dot_type;
   typedef logic signed [WIDE_W-1:0]     wide_type;

   // load enables for the two register stages of a wide multiply
   typedef struct packed {
      logic load_part;
      logic load_sum;
   } wmul_ctl_type;

endpackage

/* sv/pitb_wmul.sv */
// pitb_wmul: two-stage signed multiply of two dot products, built from
// four narrow partial products that are registered and then summed
// depends on pitb_pkg
module pitb_wmul (
   input  logic                 clock,
   input  pitb_pkg::wmul_ctl_type ctl,
   input  pitb_pkg::dot_type    op_a,
   input  pitb_pkg::dot_type    op_b,
   output pitb_pkg::wide_type   prod
);
   import pitb_pkg::*;

   logic signed [LO_W:0]   a_lo, b_lo;
   logic signed [HI_W-1:0] a_hi, b_hi;

   logic signed [LL_W-1:0] ll_in, ll_ff;
   logic signed [HL_W-1:0] hl_in, hl_ff, lh_in, lh_ff;
   logic signed [HH_W-1:0] hh_in, hh_ff;
   wide_type               prod_in, prod_ff;

   // low halves are unsigned, so they get a zero sign bit
   assign a_lo = {1'b0, op_a[LO_W-1:0]};
   assign b_lo = {1'b0, op_b[LO_W-1:0]};
   assign a_hi = op_a[DOT_W-1:LO_W];
   assign b_hi = op_b[DOT_W-1:LO_W];

   assign ll_in = LL_W'(a_lo) * LL_W'(b_lo);
   assign hl_in = HL_W'(a_hi) * HL_W'(b_lo);
   assign lh_in = HL_W'(a_lo) * HL_W'(b_hi);
   assign hh_in = HH_W'(a_hi) * HH_W'(b_hi);

   assign prod_in = (WIDE_W'(hh_ff) <<< (2 * LO_W))
                  + ((WIDE_W'(hl_ff) + WIDE_W'(lh_ff)) <<< LO_W)
                  + WIDE_W'(ll_ff);

   always_ff @(posedge clock) begin
      if (ctl.load_part) begin
         ll_ff <= ll_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         hh_ff <= hh_in;
      end
      if (ctl.load_sum) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

/* sv/point_in_triangle_barycentric.sv */
// point_in_triangle_barycentric: top level of the point-in-triangle test
// holds the seven-stage pipeline, its valid and stall logic and the checks
// depends on pitb_pkg and pitb_wmul
//
// Each item carries the vertices A, B, C of a triangle and a query point P,
// as signed COORD_BITS-bit coordinates. The block returns one result item per
// input item: degenerate is set when uu*vv - uv*uv is zero or less (collinear
// or coincident vertices) and then inside_res is 0; otherwise inside_res is 1
// when P, projected onto the triangle's plane, lies inside or on the border.
// All arithmetic is exact integer arithmetic; no division is done. The block
// is a seven-stage pipeline: edge vectors, element products, dot products,
// partial products of the wide multiplies, full products, numerators and
// denominator, then the compare into the result register. A new item is taken
// in every cycle unless req_stall is high. The 72-bit products run
// through two register stages of narrow multipliers each, which sets the
// stage count. rsp_stall holds the result register and fills the bubbles
// behind it; req_stall rises only when all seven stages hold items and the
// result is stalled.
module point_in_triangle_barycentric (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pitb_pkg::coord_type req_vertex_a_x,
   input  pitb_pkg::coord_type req_vertex_a_y,
   input  pitb_pkg::coord_type req_vertex_a_z,
   input  pitb_pkg::coord_type req_vertex_b_x,
   input  pitb_pkg::coord_type req_vertex_b_y,
   input  pitb_pkg::coord_type req_vertex_b_z,
   input  pitb_pkg::coord_type req_vertex_c_x,
   input  pitb_pkg::coord_type req_vertex_c_y,
   input  pitb_pkg::coord_type req_vertex_c_z,
   input  pitb_pkg::coord_type req_point_x,
   input  pitb_pkg::coord_type req_point_y,
   input  pitb_pkg::coord_type req_point_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_inside_res,
   output logic                rsp_degenerate
);
   import pitb_pkg::*;

   // pipeline control: a stage loads when it is empty or the next one loads
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] load;

   // input vectors by axis
   coord_type vert_a [3];
   coord_type vert_b [3];
   coord_type vert_c [3];
   coord_type pnt    [3];

   // stage: edge vectors u = C - A, v = B - A and offset w = P - A
   diff_type u_in [3], u_ff [3];
   diff_type v_in [3], v_ff [3];
   diff_type w_in [3], w_ff [3];

   // stage: element products for the five dot products
   prod_type uu_e_in [3], uu_e_ff [3];
   prod_type uv_e_in [3], uv_e_ff [3];
   prod_type vv_e_in [3], vv_e_ff [3];
   prod_type uw_e_in [3], uw_e_ff [3];
   prod_type vw_e_in [3], vw_e_ff [3];

   // stage: dot products
   dot_type uu_in, uu_ff, uv_in, uv_ff, vv_in, vv_ff, uw_in, uw_ff, vw_in, vw_ff;

   // two stages inside the wide multiplies
   wmul_ctl_type wmul_ctl;
   wide_type     p_uuvv, p_uvuv, p_vvuw, p_uvvw, p_uuvw, p_uvuw;

   // stage: denominator and the two numerators
   wide_type denom_in, denom_ff, nu_in, nu_ff, nv_in, nv_ff;

   // stage: result
   wide_type num_sum;
   logic     inside_in, inside_ff, degen_in, degen_ff;

   // ready chain from the result register back to the input
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int i = STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   always_comb begin
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         if (load[i]) begin
            valid_in[i] = valid_ff[i-1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !load[ST_DIFF];

   // vector differences
   assign vert_a = '{req_vertex_a_x, req_vertex_a_y, req_vertex_a_z};
   assign vert_b = '{req_vertex_b_x, req_vertex_b_y, req_vertex_b_z};
   assign vert_c = '{req_vertex_c_x, req_vertex_c_y, req_vertex_c_z};
   assign pnt    = '{req_point_x, req_point_y, req_point_z};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_in[k] = DIFF_W'(vert_c[k]) - DIFF_W'(vert_a[k]);
         v_in[k] = DIFF_W'(vert_b[k]) - DIFF_W'(vert_a[k]);
         w_in[k] = DIFF_W'(pnt[k])    - DIFF_W'(vert_a[k]);
      end
   end

   // element products, one 17x17 multiply each at the default width
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         uu_e_in[k] = PROD_W'(u_ff[k]) * PROD_W'(u_ff[k]);
         uv_e_in[k] = PROD_W'(u_ff[k]) * PROD_W'(v_ff[k]);
         vv_e_in[k] = PROD_W'(v_ff[k]) * PROD_W'(v_ff[k]);
         uw_e_in[k] = PROD_W'(u_ff[k]) * PROD_W'(w_ff[k]);
         vw_e_in[k] = PROD_W'(v_ff[k]) * PROD_W'(w_ff[k]);
      end
   end

   // three-way sums
   assign uu_in = DOT_W'(uu_e_ff[0]) + DOT_W'(uu_e_ff[1]) + DOT_W'(uu_e_ff[2]);
   assign uv_in = DOT_W'(uv_e_ff[0]) + DOT_W'(uv_e_ff[1]) + DOT_W'(uv_e_ff[2]);
   assign vv_in = DOT_W'(vv_e_ff[0]) + DOT_W'(vv_e_ff[1]) + DOT_W'(vv_e_ff[2]);
   assign uw_in = DOT_W'(uw_e_ff[0]) + DOT_W'(uw_e_ff[1]) + DOT_W'(uw_e_ff[2]);
   assign vw_in = DOT_W'(vw_e_ff[0]) + DOT_W'(vw_e_ff[1]) + DOT_W'(vw_e_ff[2]);

   always_ff @(posedge clock) begin
      if (load[ST_DIFF]) begin
         u_ff <= u_in;
         v_ff <= v_in;
         w_ff <= w_in;
      end
      if (load[ST_ELEM]) begin
         uu_e_ff <= uu_e_in;
         uv_e_ff <= uv_e_in;
         vv_e_ff <= vv_e_in;
         uw_e_ff <= uw_e_in;
         vw_e_ff <= vw_e_in;
      end
      if (load[ST_DOT]) begin
         uu_ff <= uu_in;
         uv_ff <= uv_in;
         vv_ff <= vv_in;
         uw_ff <= uw_in;
         vw_ff <= vw_in;
      end
   end

   // six wide products, two stages each
   assign wmul_ctl.load_part = load[ST_PART];
   assign wmul_ctl.load_sum  = load[ST_PROD];

   pitb_wmul u_mul_uuvv (.clock(clock), .ctl(wmul_ctl), .op_a(uu_ff), .op_b(vv_ff),
                         .prod(p_uuvv));
   pitb_wmul u_mul_uvuv (.clock(clock), .ctl(wmul_ctl), .op_a(uv_ff), .op_b(uv_ff),
                         .prod(p_uvuv));
   pitb_wmul u_mul_vvuw (.clock(clock), .ctl(wmul_ctl), .op_a(vv_ff), .op_b(uw_ff),
                         .prod(p_vvuw));
   pitb_wmul u_mul_uvvw (.clock(clock), .ctl(wmul_ctl), .op_a(uv_ff), .op_b(vw_ff),
                         .prod(p_uvvw));
   pitb_wmul u_mul_uuvw (.clock(clock), .ctl(wmul_ctl), .op_a(uu_ff), .op_b(vw_ff),
                         .prod(p_uuvw));
   pitb_wmul u_mul_uvuw (.clock(clock), .ctl(wmul_ctl), .op_a(uv_ff), .op_b(uw_ff),
                         .prod(p_uvuw));

   // denominator and numerators
   assign denom_in = p_uuvv - p_uvuv;
   assign nu_in    = p_vvuw - p_uvvw;
   assign nv_in    = p_uuvw - p_uvuw;

   // final compare, border points count as inside
   assign num_sum   = nu_ff + nv_ff;
   assign degen_in  = denom_ff[WIDE_W-1] || (denom_ff == '0);
   assign inside_in = !degen_in && !nu_ff[WIDE_W-1] && !nv_ff[WIDE_W-1]
                      && (num_sum <= denom_ff);

   always_ff @(posedge clock) begin
      if (load[ST_NUM]) begin
         denom_ff <= denom_in;
         nu_ff    <= nu_in;
         nv_ff    <= nv_in;
      end
      if (load[ST_RES]) begin
         inside_ff <= inside_in;
         degen_ff  <= degen_in;
      end
   end

   assign rsp_valid      = valid_ff[ST_RES];
   assign rsp_inside_res = inside_ff;
   assign rsp_degenerate = degen_ff;

   // checks

   // the pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline holds items after reset");

   // the input stalls only with every stage full and the result stalled
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // an item in the numerator stage moves into the result register
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_NUM] && load[ST_RES]) |=> valid_ff[ST_RES])
      else $error("item lost between numerator and result stages");

   // a zero denominator always ends as degenerate
   a_zero_denom: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_NUM] && load[ST_RES] && (denom_ff == '0)) |=> rsp_degenerate)
      else $error("zero denominator not flagged");

   // a degenerate triangle never reports inside
   a_degen_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_inside_res && rsp_degenerate))
      else $error("inside reported for degenerate triangle");

endmodule

/* dv/tb_point_in_triangle_barycentric.sv */
// tb_point_in_triangle_barycentric: self-checking testbench for the
// barycentric point-in-triangle pipeline, with an exact-integer predictor
// depends on pitb_pkg and the point_in_triangle_barycentric rtl
module tb_point_in_triangle_barycentric;
   timeunit 1ns;
   timeprecision 1ps;

   import pitb_pkg::*;

   localparam int COORD_MAX   = 32767;
   localparam int COORD_MIN   = -32768;
   // run limit, far above the slowest legal run of about a thousand items
   localparam int CYCLE_LIMIT = 200000;
   // cycles to watch the result port after the last result, well past latency
   localparam int TAIL_CYCLES = 4 * STAGES;
   localparam int DIRECTED_ROWS = 24;

   // how a directed row is checked: typed answer, or the predictor
   typedef enum int {
      CHECK_MODEL,
      CHECK_OUTSIDE,
      CHECK_INSIDE,
      CHECK_DEGENERATE
   } golden_kind_type;

   // one query: ax ay az bx by bz cx cy cz px py pz
   typedef coord_type coord_set_type [12];

   typedef struct packed {
      logic inside_res;
      logic degenerate;
   } hit_type;

   // wide enough for every exact product and difference of the test
   typedef logic signed [127:0] exact_type;

   // directed stimulus: twelve coordinates, then how the answer is known
   localparam int DIRECTED_CASES [DIRECTED_ROWS][13] = '{
      // all vertices and the point coincide
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, CHECK_DEGENERATE},
      '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
        CHECK_DEGENERATE},
      '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
        CHECK_DEGENERATE},
      // collinear vertices
      '{0, 0, 0, 1, 1, 1, 2, 2, 2, 1, 1, 1, CHECK_DEGENERATE},
      // two coincident vertices
      '{5, 5, 5, 5, 5, 5, 9, -3, 7, 5, 5, 5, CHECK_DEGENERATE},
      // right triangle in the xy plane: interior, far outside
      '{0, 0, 0, 100, 0, 0, 0, 100, 0, 10, 10, 0, CHECK_INSIDE},
      '{0, 0, 0, 100, 0, 0, 0, 100, 0, 200, 200, 0, CHECK_OUTSIDE},
      // each vertex counts as inside
      '{0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 0, CHECK_INSIDE},
      '{0, 0, 0, 100, 0, 0, 0, 100, 0, 100, 0, 0, CHECK_INSIDE},
      '{0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 100, 0, CHECK_INSIDE},
      // on edge ab, on edge bc (numerators sum to denom)
      '{0, 0, 0, 100, 0, 0, 0, 100, 0, 50, 0, 0, CHECK_INSIDE},
      '{0, 0, 0, 100, 0, 0, 0, 100, 0, 50, 50, 0, CHECK_INSIDE},
      // one step outside an edge
      '{0, 0, 0, 100, 0, 0, 0, 100, 0, -1, 0, 0, CHECK_OUTSIDE},
      '{0, 0, 0, 100, 0, 0, 0, 100, 0, 51, 50, 0, CHECK_OUTSIDE},
      // point far off the plane: projects inside, projects outside
      '{0, 0, 0, 100, 0, 0, 0, 100, 0, 10, 10, 30000, CHECK_INSIDE},
      '{0, 0, 0, 100, 0, 0, 0, 100, 0, COORD_MIN, COORD_MIN, COORD_MIN,
        CHECK_OUTSIDE},
      // full-range triangles, point near the long edge or on a vertex
      '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
        COORD_MIN, COORD_MAX, COORD_MIN, 0, 0, COORD_MAX, CHECK_MODEL},
      '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
        COORD_MIN, COORD_MAX, COORD_MIN, -1, -1, 0, CHECK_MODEL},
      '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
        COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
        CHECK_INSIDE},
      // tilted triangle in 3d
      '{1, 2, 3, 40, -7, 11, -13, 25, -30, 9, 7, -5, CHECK_MODEL},
      // alternating bit patterns
      '{21845, -21846, 21845, -21846, 21845, -21846, 21845, 21845, -21846,
        -21846, -21846, 21845, CHECK_MODEL},
      // unit triangle, point just past the hypotenuse
      '{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0, CHECK_OUTSIDE},
      // collinear across the full range
      '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
        0, 0, 0, 0, 0, 0, CHECK_DEGENERATE},
      // tiny triangle in the yz plane, far point projects onto the border
      '{0, 0, 0, 0, 2, 0, 0, 0, 2, COORD_MAX, 1, 1, CHECK_INSIDE}
   };

   localparam int PHASE_ITEMS [3] = '{320, 320, 310};
   localparam int SENDER_IDLE [3] = '{9, 72, 0};
   localparam int RECEIVER_IDLE [3] = '{72, 9, 0};

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   coord_type req_vertex_a_x = '0;
   coord_type req_vertex_a_y = '0;
   coord_type req_vertex_a_z = '0;
   coord_type req_vertex_b_x = '0;
   coord_type req_vertex_b_y = '0;
   coord_type req_vertex_b_z = '0;
   coord_type req_vertex_c_x = '0;
   coord_type req_vertex_c_y = '0;
   coord_type req_vertex_c_z = '0;
   coord_type req_point_x = '0;
   coord_type req_point_y = '0;
   coord_type req_point_z = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic      rsp_inside_res;
   logic      rsp_degenerate;

   // answers for accepted items, oldest first
   hit_type pending_hits [$];
   int   failures = 0;
   int   cycle_count = 0;
   int   items_sent = 0;
   int   inside_seen = 0;
   int   outside_seen = 0;
   int   degenerate_seen = 0;
   // idle rates in percent, changed per phase
   int   sender_idle_pct = 0;
   int   receiver_idle_pct = 0;

   point_in_triangle_barycentric u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_vertex_a_x (req_vertex_a_x),
      .req_vertex_a_y (req_vertex_a_y),
      .req_vertex_a_z (req_vertex_a_z),
      .req_vertex_b_x (req_vertex_b_x),
      .req_vertex_b_y (req_vertex_b_y),
      .req_vertex_b_z (req_vertex_b_z),
      .req_vertex_c_x (req_vertex_c_x),
      .req_vertex_c_y (req_vertex_c_y),
      .req_vertex_c_z (req_vertex_c_z),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_inside_res (rsp_inside_res),
      .rsp_degenerate (rsp_degenerate)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // exact barycentric test: edge vectors, dot products, then the
   // division-free compare of both numerators against the denominator
   function automatic hit_type classify_point(input coord_set_type crd);
      longint u [3];
      longint v [3];
      longint w [3];
      longint uu, uv, vv, uw, vw;
      exact_type e_uu, e_uv, e_vv, e_uw, e_vw;
      exact_type denom, nu, nv;
      hit_type   hit;
      for (int k = 0; k < 3; k++) begin
         u[k] = longint'(crd[6 + k]) - longint'(crd[k]);
         v[k] = longint'(crd[3 + k]) - longint'(crd[k]);
         w[k] = longint'(crd[9 + k]) - longint'(crd[k]);
      end
      uu = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
      uv = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
      vv = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      uw = u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
      vw = v[0] * w[0] + v[1] * w[1] + v[2] * w[2];
      // sign-extend into the wide type before any product
      e_uu = uu;
      e_uv = uv;
      e_vv = vv;
      e_uw = uw;
      e_vw = vw;
      denom = e_uu * e_vv - e_uv * e_uv;
      hit.inside_res = 1'b0;
      hit.degenerate = 1'b0;
      if (denom <= 0) begin
         // flat triangle: no inside answer
         hit.degenerate = 1'b1;
      end else begin
         nu = e_vv * e_uw - e_uv * e_vw;
         nv = e_uu * e_vw - e_uv * e_uw;
         // border points count as inside
         hit.inside_res = (nu >= 0) && (nv >= 0) && (nu + nv <= denom);
      end
      return hit;
   endfunction

   function automatic int rand_coord(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   // random query; most shapes are built so that borders, degenerate
   // triangles and points near the triangle come up often
   task automatic draw_query(output coord_set_type crd);
      int pts [4][3];
      int dir [3];
      int shape, wa, wb, wc, span, step, rot, m;
      shape = $urandom_range(99);
      rot = $urandom_range(2);
      if (shape < 20) begin
         // full-range noise, every bit pattern possible
         for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++)
               pts[i][k] = rand_coord(COORD_MIN, COORD_MAX);
      end else if (shape < 30) begin
         // corners of the coordinate range mixed with small values
         for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++)
               case ($urandom_range(5))
                  0: pts[i][k] = COORD_MIN;
                  1: pts[i][k] = COORD_MAX;
                  2: pts[i][k] = 0;
                  3: pts[i][k] = -1;
                  4: pts[i][k] = 1;
                  default: pts[i][k] = rand_coord(COORD_MIN, COORD_MAX);
               endcase
      end else if (shape < 55) begin
         // point as a weighted mean of the vertices, inside or on a border
         wa = $urandom_range(15);
         wb = $urandom_range(15);
         wc = $urandom_range(15);
         if (wa + wb + wc == 0)
            wa = 1;
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
               pts[i][k] = rand_coord(-12000, 12000);
         for (int k = 0; k < 3; k++)
            pts[3][k] = (wa * pts[0][k] + wb * pts[1][k] + wc * pts[2][k])
                        / (wa + wb + wc);
      end else if (shape < 75) begin
         // point exactly on an edge line, on a vertex or one step beyond
         span = $urandom_range(20, 1);
         step = int'($urandom_range(span + 2)) - 1;
         for (int k = 0; k < 3; k++) begin
            dir[k] = rand_coord(-500, 500);
            pts[0][k] = rand_coord(-10000, 10000);
            pts[1][k] = pts[0][k] + span * dir[k];
            pts[2][k] = rand_coord(-16000, 16000);
            pts[3][k] = pts[0][k] + step * dir[k];
         end
      end else if (shape < 85) begin
         // collinear or coincident vertices
         m = rand_coord(-20, 20);
         for (int k = 0; k < 3; k++) begin
            dir[k] = ($urandom_range(7) == 0) ? 0 : rand_coord(-500, 500);
            pts[0][k] = rand_coord(-1000, 1000);
            pts[1][k] = pts[0][k] + dir[k];
            pts[2][k] = pts[0][k] + m * dir[k];
            pts[3][k] = rand_coord(-16000, 16000);
         end
      end else begin
         // tiny lattice, dense in borders and flat cases
         for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++)
               pts[i][k] = rand_coord(-3, 3);
      end
      // rotate the vertex roles so every edge sees the border cases
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            crd[3 * ((i + rot) % 3) + k] = coord_type'(pts[i][k]);
      for (int k = 0; k < 3; k++)
         crd[9 + k] = coord_type'(pts[3][k]);
   endtask

   // present one item, holding it until accepted; entered and left at a
   // falling edge; the answer is queued at the accepting edge
   task automatic offer_query(input coord_set_type crd, input hit_type answer);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_vertex_a_x <= crd[0];
      req_vertex_a_y <= crd[1];
      req_vertex_a_z <= crd[2];
      req_vertex_b_x <= crd[3];
      req_vertex_b_y <= crd[4];
      req_vertex_b_z <= crd[5];
      req_vertex_c_x <= crd[6];
      req_vertex_c_y <= crd[7];
      req_vertex_c_z <= crd[8];
      req_point_x    <= crd[9];
      req_point_y    <= crd[10];
      req_point_z    <= crd[11];
      req_valid      <= 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      pending_hits.push_back(answer);
      items_sent++;
      @(negedge clock);
   endtask

   // hold off the sender until every outstanding result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_hits.size() != 0)
         @(negedge clock);
   endtask

   // receiver: stall at random at the current rate
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   // result checker: every accepted result against the oldest answer
   always @(posedge clock) begin : check_results
      hit_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hits.size() == 0) begin
            $error("result item with no item outstanding: inside_res %0b degenerate %0b",
                   rsp_inside_res, rsp_degenerate);
            failures++;
         end else begin
            want = pending_hits.pop_front();
            if (rsp_inside_res !== want.inside_res) begin
               $error("inside_res: expected %0b, got %0b", want.inside_res, rsp_inside_res);
               failures++;
            end
            if (rsp_degenerate !== want.degenerate) begin
               $error("degenerate: expected %0b, got %0b", want.degenerate, rsp_degenerate);
               failures++;
            end
            if (want.degenerate)
               degenerate_seen++;
            else if (want.inside_res)
               inside_seen++;
            else
               outside_seen++;
         end
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_hits.size());
         $display("** point_in_triangle_barycentric: FAILED **");
         $finish;
      end
   end

   initial begin
      coord_set_type   crd;
      hit_type         answer;
      golden_kind_type kind;

      sender_idle_pct = SENDER_IDLE[0];
      receiver_idle_pct = RECEIVER_IDLE[0];
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows, typed answers where they are obvious
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         for (int i = 0; i < 12; i++)
            crd[i] = coord_type'(DIRECTED_CASES[r][i]);
         kind = golden_kind_type'(DIRECTED_CASES[r][12]);
         case (kind)
            CHECK_INSIDE:     answer = '{inside_res: 1'b1, degenerate: 1'b0};
            CHECK_OUTSIDE:    answer = '{inside_res: 1'b0, degenerate: 1'b0};
            CHECK_DEGENERATE: answer = '{inside_res: 1'b0, degenerate: 1'b1};
            default:          answer = classify_point(crd);
         endcase
         offer_query(crd, answer);
      end

      // three random phases with different idle patterns; between phases
      // the sender waits until the pipeline has emptied
      for (int ph = 0; ph < 3; ph++) begin
         sender_idle_pct = SENDER_IDLE[ph];
         receiver_idle_pct = RECEIVER_IDLE[ph];
         for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
            draw_query(crd);
            offer_query(crd, classify_point(crd));
         end
         wait_for_results();
      end

      // keep watching the result port for strays
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("sent %0d items over three idle patterns in %0d cycles", items_sent,
               cycle_count);
      $display("results: %0d inside, %0d outside, %0d degenerate", inside_seen,
               outside_seen, degenerate_seen);
      if (failures == 0) begin
         $display("** point_in_triangle_barycentric: PASSED **");
      end else begin
         $display("** point_in_triangle_barycentric: FAILED **");
      end
      $finish;
   end

endmodule
